### sv/mhtq_pkg.sv
`default_nettype none
package mhtq_pkg;

   localparam int HeapDepthDefault = 64;
   localparam int IdCountDefault   = 256;
   localparam int TimeBitsDefault  = 32;

   typedef enum logic [1:0] {
      FUNC_ADD    = 2'd0,
      FUNC_ADJUST = 2'd1,
      FUNC_DELETE = 2'd2,
      FUNC_TICK   = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_DONE    = 3'd0,
      ST_EXPIRED = 3'd1,
      ST_ABSENT  = 3'd2,
      ST_REJECT  = 3'd3,
      ST_NONE    = 3'd4
   } status_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_DISPATCH,
      S_POS,
      S_DEL_A,
      S_DEL_B,
      S_UP,
      S_UP_CMP,
      S_PLACE_UP,
      S_DN_RD,
      S_DN_SELF,
      S_DN,
      S_DN_L,
      S_DN_R,
      S_PLACE_DN,
      S_TK_RD,
      S_TK_CMP,
      S_TK_POP,
      S_TK_LAST,
      S_EMIT
   } state_type;

endpackage
`default_nettype wire

### sv/mhtq_if.sv
`default_nettype none
interface mhtq_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [7:0]  timer_id;
   logic [31:0] expiry_ms;
   logic [31:0] now_time;
   modport source (output valid, func, timer_id, expiry_ms, now_time, input ready);
   modport sink (input valid, func, timer_id, expiry_ms, now_time, output ready);
endinterface

interface mhtq_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [7:0]  out_id;
   logic [31:0] out_expire;
   logic [6:0]  entries_left;
   logic        last;
   modport source (output valid, status, out_id, out_expire, entries_left, last, input ready);
   modport sink (input valid, status, out_id, out_expire, entries_left, last, output ready);
endinterface
`default_nettype wire

### sv/min_heap_timer_queue_top.sv
// add sifts the new item up from the end of the heap; adjust sifts it up, then down;
// delete first moves the last item into the hole, then sifts it; an empty tick answers none
// tick: each expired item is popped and the last item sifted down from the root, then it finishes
// one item at a time: the next item is taken after its last result is registered
// reset: synchronous, active high; clears the heap count and all presence bits,
// heap and position memories are not cleared and are only read where written
`default_nettype none
module min_heap_timer_queue_top
   import mhtq_pkg::*;
#(
   parameter int HEAP_DEPTH = HeapDepthDefault,
   parameter int ID_COUNT   = IdCountDefault,
   parameter int TIME_BITS  = TimeBitsDefault
) (
   input  wire logic   clock,
   input  wire logic   reset,
   mhtq_req_if.sink    req_ch,
   mhtq_rsp_if.source  rsp_ch
);

   localparam int SW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
   localparam int CW = $clog2(HEAP_DEPTH + 1);
   localparam int XW = SW + 2;
   localparam int IW = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1;
   localparam int TW = TIME_BITS;

   // heap storage: id and expiry per slot, position per timer id
   logic [7:0]    heap_id_mem [HEAP_DEPTH];
   logic [TW-1:0] heap_ex_mem [HEAP_DEPTH];
   logic [SW-1:0] pos_mem     [ID_COUNT];

   // control and datapath registers
   state_type     state_ff, state_in;
   func_type      op_ff, op_in;
   logic [7:0]    id_ff, id_in;
   logic [TW-1:0] ex_ff, ex_in;
   logic [TW-1:0] now_ff, now_in;
   logic [CW-1:0] count_ff, count_in;
   logic [SW-1:0] i_ff, i_in;
   logic [SW-1:0] i0_ff, i0_in;
   logic [7:0]    cur_id_ff, cur_id_in;
   logic [TW-1:0] cur_ex_ff, cur_ex_in;
   logic [7:0]    l_id_ff, l_id_in;
   logic [TW-1:0] l_ex_ff, l_ex_in;
   logic          lless_ff, lless_in;
   status_type    res_status_ff, res_status_in;
   logic [7:0]    res_id_ff, res_id_in;
   logic [TW-1:0] res_ex_ff, res_ex_in;
   logic [CW-1:0] res_left_ff, res_left_in;
   logic          res_last_ff, res_last_in;
   logic          pend_ff, pend_in;
   logic          flush_ff, flush_in;
   logic [ID_COUNT-1:0] present_ff;

   // response output register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [2:0]    rsp_status_ff, rsp_status_in;
   logic [7:0]    rsp_id_ff, rsp_id_in;
   logic [31:0]   rsp_ex_ff, rsp_ex_in;
   logic [6:0]    rsp_left_ff, rsp_left_in;
   logic          rsp_last_ff, rsp_last_in;

   // memory read data
   logic [7:0]    hq_id_ff;
   logic [TW-1:0] hq_ex_ff;
   logic [SW-1:0] pq_ff;

   // memory controls
   logic          h_re, h_we, p_re, p_we;
   logic [SW-1:0] h_ra, h_wa;
   logic [7:0]    h_wid;
   logic [TW-1:0] h_wex;
   logic [IW-1:0] p_ra, p_wa;
   logic [SW-1:0] p_wd;
   logic          pres_set, pres_clr;
   logic [IW-1:0] pres_idx;

   function automatic logic [IW-1:0] id_index(input logic [7:0] v);
      logic [15:0] w;
      w = 16'(v);
      return w[IW-1:0];
   endfunction

   function automatic logic [TW-1:0] to_time(input logic [31:0] v);
      logic [63:0] w;
      w = 64'(v);
      return w[TW-1:0];
   endfunction

   // shared index arithmetic
   logic [XW-1:0] ix, cx, lx, rx, cm1x, px;
   logic          known, here, full, r_less;
   logic [TW-1:0] best_ex;
   logic          accept;
   logic          out_free;
   logic [63:0]   res_ex_wide;
   logic [63:0]   left_wide;

   assign ix     = XW'(i_ff);
   assign cx     = XW'(count_ff);
   assign lx     = (ix << 1) + XW'(1);
   assign rx     = lx + XW'(1);
   assign cm1x   = cx - XW'(1);
   assign px     = (ix - XW'(1)) >> 1;
   assign known  = 32'(id_ff) < 32'(ID_COUNT);
   assign here   = known && present_ff[id_index(id_ff)];
   assign full   = cx >= XW'(HEAP_DEPTH);
   assign best_ex = lless_ff ? l_ex_ff : cur_ex_ff;
   assign r_less = hq_ex_ff < best_ex;
   assign accept = req_ch.valid && req_ch.ready;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   assign req_ch.ready        = (state_ff == S_IDLE);
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.out_id       = rsp_id_ff;
   assign rsp_ch.out_expire   = rsp_ex_ff;
   assign rsp_ch.entries_left = rsp_left_ff;
   assign rsp_ch.last         = rsp_last_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            case (op_ff)
               FUNC_ADD:    state_in = (!known || here || full) ? S_EMIT : S_UP;
               FUNC_ADJUST: state_in = here ? S_POS : S_EMIT;
               FUNC_DELETE: state_in = here ? S_POS : S_EMIT;
               default:     state_in = S_TK_RD;
            endcase
         end
         S_POS: begin
            if (XW'(pq_ff) >= cx) state_in = S_EMIT;
            else if (op_ff == FUNC_ADJUST) state_in = S_UP;
            else state_in = S_DEL_A;
         end
         S_DEL_A: state_in = S_DEL_B;
         S_DEL_B: state_in = (ix < cm1x) ? S_UP : S_EMIT;
         S_UP:    state_in = (i_ff == '0) ? S_PLACE_UP : S_UP_CMP;
         S_UP_CMP: state_in = (cur_ex_ff < hq_ex_ff) ? S_UP : S_PLACE_UP;
         S_PLACE_UP: state_in = (op_ff == FUNC_ADD) ? S_EMIT : S_DN_RD;
         S_DN_RD:   state_in = S_DN_SELF;
         S_DN_SELF: state_in = S_DN;
         S_DN:      state_in = (lx >= cx) ? S_PLACE_DN : S_DN_L;
         S_DN_L: begin
            if (rx < cx) state_in = S_DN_R;
            else if (hq_ex_ff < cur_ex_ff) state_in = S_DN;
            else state_in = S_PLACE_DN;
         end
         S_DN_R: state_in = (r_less || lless_ff) ? S_DN : S_PLACE_DN;
         S_PLACE_DN: state_in = (op_ff == FUNC_TICK) ? S_TK_RD : S_EMIT;
         S_TK_RD:  state_in = (count_ff == '0) ? S_EMIT : S_TK_CMP;
         S_TK_CMP: begin
            if (hq_ex_ff <= now_ff) state_in = pend_ff ? S_EMIT : S_TK_POP;
            else state_in = S_EMIT;
         end
         S_TK_POP:  state_in = S_TK_LAST;
         S_TK_LAST: state_in = (cm1x > XW'(0)) ? S_UP : S_TK_RD;
         S_EMIT: begin
            if (out_free) state_in = flush_ff ? S_TK_POP : S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      op_in = op_ff; id_in = id_ff; ex_in = ex_ff; now_in = now_ff;
      count_in = count_ff; i_in = i_ff; i0_in = i0_ff;
      cur_id_in = cur_id_ff; cur_ex_in = cur_ex_ff;
      l_id_in = l_id_ff; l_ex_in = l_ex_ff; lless_in = lless_ff;
      res_status_in = res_status_ff; res_id_in = res_id_ff; res_ex_in = res_ex_ff;
      res_left_in = res_left_ff; res_last_in = res_last_ff;
      pend_in = pend_ff; flush_in = flush_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff; rsp_id_in = rsp_id_ff; rsp_ex_in = rsp_ex_ff;
      rsp_left_in = rsp_left_ff; rsp_last_in = rsp_last_ff;
      h_re = 1'b0; h_ra = '0; h_we = 1'b0; h_wa = '0; h_wid = '0; h_wex = '0;
      p_re = 1'b0; p_ra = '0; p_we = 1'b0; p_wa = '0; p_wd = '0;
      pres_set = 1'b0; pres_clr = 1'b0; pres_idx = '0;
      res_ex_wide = 64'(res_ex_ff);
      left_wide = 64'((op_ff == FUNC_TICK) ? res_left_ff : count_ff);
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in  = func_type'(req_ch.func);
               id_in  = req_ch.timer_id;
               ex_in  = to_time(req_ch.expiry_ms);
               now_in = to_time(req_ch.now_time);
            end
         end
         S_DISPATCH: begin
            res_id_in = id_ff;
            res_last_in = 1'b1;
            flush_in = 1'b0;
            pend_in = 1'b0;
            case (op_ff)
               FUNC_ADD: begin
                  if (!known || here || full) begin
                     res_status_in = ST_REJECT;
                     res_ex_in = '0;
                  end else begin
                     res_status_in = ST_DONE;
                     res_ex_in = ex_ff;
                     cur_id_in = id_ff;
                     cur_ex_in = ex_ff;
                     i_in = count_ff[SW-1:0];
                     i0_in = count_ff[SW-1:0];
                     count_in = count_ff + CW'(1);
                     pres_set = 1'b1;
                     pres_idx = id_index(id_ff);
                  end
               end
               FUNC_ADJUST, FUNC_DELETE: begin
                  res_status_in = ST_ABSENT;
                  res_ex_in = '0;
                  p_re = 1'b1;
                  p_ra = id_index(id_ff);
               end
               default: begin
               end
            endcase
         end
         S_POS: begin
            i_in = pq_ff;
            i0_in = pq_ff;
            if (XW'(pq_ff) < cx) begin
               res_status_in = ST_DONE;
               if (op_ff == FUNC_ADJUST) begin
                  res_ex_in = ex_ff;
                  cur_id_in = id_ff;
                  cur_ex_in = ex_ff;
               end else begin
                  h_re = 1'b1;
                  h_ra = pq_ff;
               end
            end
         end
         S_DEL_A: begin
            res_ex_in = hq_ex_ff;
            h_re = 1'b1;
            h_ra = cm1x[SW-1:0];
         end
         S_DEL_B: begin
            cur_id_in = hq_id_ff;
            cur_ex_in = hq_ex_ff;
            count_in = cm1x[CW-1:0];
            pres_clr = 1'b1;
            pres_idx = id_index(id_ff);
         end
         S_UP: begin
            if (i_ff != '0) begin
               h_re = 1'b1;
               h_ra = px[SW-1:0];
            end
         end
         S_UP_CMP: begin
            // parent moves down into the hole
            if (cur_ex_ff < hq_ex_ff) begin
               h_we = 1'b1; h_wa = i_ff; h_wid = hq_id_ff; h_wex = hq_ex_ff;
               p_we = 1'b1; p_wa = id_index(hq_id_ff); p_wd = i_ff;
               i_in = px[SW-1:0];
            end
         end
         S_PLACE_UP: begin
            h_we = 1'b1; h_wa = i_ff; h_wid = cur_id_ff; h_wex = cur_ex_ff;
            p_we = 1'b1; p_wa = id_index(cur_id_ff); p_wd = i_ff;
            i_in = i0_ff;
         end
         S_DN_RD: begin
            h_re = 1'b1;
            h_ra = i_ff;
         end
         S_DN_SELF: begin
            cur_id_in = hq_id_ff;
            cur_ex_in = hq_ex_ff;
         end
         S_DN: begin
            if (lx < cx) begin
               h_re = 1'b1;
               h_ra = lx[SW-1:0];
            end
         end
         S_DN_L: begin
            l_id_in = hq_id_ff;
            l_ex_in = hq_ex_ff;
            lless_in = hq_ex_ff < cur_ex_ff;
            if (rx < cx) begin
               h_re = 1'b1;
               h_ra = rx[SW-1:0];
            end else if (hq_ex_ff < cur_ex_ff) begin
               h_we = 1'b1; h_wa = i_ff; h_wid = hq_id_ff; h_wex = hq_ex_ff;
               p_we = 1'b1; p_wa = id_index(hq_id_ff); p_wd = i_ff;
               i_in = lx[SW-1:0];
            end
         end
         S_DN_R: begin
            // right child wins only when strictly below the better of self and left
            if (r_less) begin
               h_we = 1'b1; h_wa = i_ff; h_wid = hq_id_ff; h_wex = hq_ex_ff;
               p_we = 1'b1; p_wa = id_index(hq_id_ff); p_wd = i_ff;
               i_in = rx[SW-1:0];
            end else if (lless_ff) begin
               h_we = 1'b1; h_wa = i_ff; h_wid = l_id_ff; h_wex = l_ex_ff;
               p_we = 1'b1; p_wa = id_index(l_id_ff); p_wd = i_ff;
               i_in = lx[SW-1:0];
            end
         end
         S_PLACE_DN: begin
            h_we = 1'b1; h_wa = i_ff; h_wid = cur_id_ff; h_wex = cur_ex_ff;
            p_we = 1'b1; p_wa = id_index(cur_id_ff); p_wd = i_ff;
         end
         S_TK_RD: begin
            if (count_ff == '0) begin
               flush_in = 1'b0;
               res_last_in = 1'b1;
               if (!pend_ff) begin
                  res_status_in = ST_NONE;
                  res_id_in = '0;
                  res_ex_in = '0;
                  res_left_in = count_ff;
               end
            end else begin
               h_re = 1'b1;
               h_ra = '0;
            end
         end
         S_TK_CMP: begin
            if (hq_ex_ff <= now_ff) begin
               // earlier expired item is not the final one
               flush_in = pend_ff;
               res_last_in = 1'b0;
            end else begin
               flush_in = 1'b0;
               res_last_in = 1'b1;
               if (!pend_ff) begin
                  res_status_in = ST_NONE;
                  res_id_in = '0;
                  res_ex_in = '0;
                  res_left_in = count_ff;
               end
            end
         end
         S_TK_POP: begin
            res_status_in = ST_EXPIRED;
            res_id_in = hq_id_ff;
            res_ex_in = hq_ex_ff;
            res_last_in = 1'b0;
            flush_in = 1'b0;
            pres_clr = 1'b1;
            pres_idx = id_index(hq_id_ff);
            i_in = '0;
            i0_in = '0;
            h_re = 1'b1;
            h_ra = cm1x[SW-1:0];
         end
         S_TK_LAST: begin
            cur_id_in = hq_id_ff;
            cur_ex_in = hq_ex_ff;
            count_in = cm1x[CW-1:0];
            res_left_in = cm1x[CW-1:0];
            pend_in = 1'b1;
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_id_in = res_id_ff;
               rsp_ex_in = res_ex_wide[31:0];
               rsp_left_in = left_wide[6:0];
               rsp_last_in = res_last_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // memories
   always_ff @(posedge clock) begin
      if (h_we) begin
         heap_id_mem[h_wa] <= h_wid;
         heap_ex_mem[h_wa] <= h_wex;
      end
      if (h_re) begin
         hq_id_ff <= heap_id_mem[h_ra];
         hq_ex_ff <= heap_ex_mem[h_ra];
      end
      if (p_we) pos_mem[p_wa] <= p_wd;
      if (p_re) pq_ff <= pos_mem[p_ra];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         present_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         flush_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
         flush_ff     <= flush_in;
         if (pres_set) present_ff[pres_idx] <= 1'b1;
         if (pres_clr) present_ff[pres_idx] <= 1'b0;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      op_ff <= op_in; id_ff <= id_in; ex_ff <= ex_in; now_ff <= now_in;
      i_ff <= i_in; i0_ff <= i0_in;
      cur_id_ff <= cur_id_in; cur_ex_ff <= cur_ex_in;
      l_id_ff <= l_id_in; l_ex_ff <= l_ex_in; lless_ff <= lless_in;
      res_status_ff <= res_status_in; res_id_ff <= res_id_in; res_ex_ff <= res_ex_in;
      res_left_ff <= res_left_in; res_last_ff <= res_last_in;
      rsp_status_ff <= rsp_status_in; rsp_id_ff <= rsp_id_in; rsp_ex_ff <= rsp_ex_in;
      rsp_left_ff <= rsp_left_in; rsp_last_ff <= rsp_last_in;
   end

endmodule
`default_nettype wire
